// ----- sv/gfr_pkg.sv -----
package gfr_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF = 4;

  localparam int GLYPH_WIDTH = 5;
  localparam int GLYPH_HEIGHT = 7;
  localparam int LETTER_BASE = 11;
  localparam logic [7:0] GLYPH_ROWS_MASK = 8'h7F;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic clr_write;
    logic col_start;
    logic col_read;
    logic col_write;
    logic byte_read;
    logic load_result;
  } gfr_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    draw_ok;
    logic    clr_last;
    logic    col_done;
  } gfr_sts_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] idx;
  } glyph_sel_t;

  // Map a character code to its font entry: space, then digits, then letters.
  function automatic glyph_sel_t glyph_lookup(input logic [7:0] code);
    glyph_sel_t sel;
    sel.ok  = 1'b0;
    sel.idx = 6'd0;
    if (code >= 8'h30 && code <= 8'h39) begin
      sel.ok  = 1'b1;
      sel.idx = 6'(code - 8'h30) + 6'd1;
    end else if (code >= 8'h41 && code <= 8'h5A) begin
      sel.ok  = 1'b1;
      sel.idx = 6'(code - 8'h41) + 6'(LETTER_BASE);
    end else if (code == 8'h20) begin
      sel.ok  = 1'b1;
      sel.idx = 6'd0;
    end
    return sel;
  endfunction

  // Five glyph columns, column 0 in the low byte; bit j is glyph row j.
  function automatic logic [39:0] font_glyph(input logic [5:0] idx);
    logic [39:0] g;
    unique case (idx)
      6'd0:  g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      6'd1:  g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
      6'd2:  g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
      6'd3:  g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
      6'd4:  g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
      6'd5:  g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
      6'd6:  g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
      6'd7:  g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
      6'd8:  g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
      6'd9:  g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      6'd10: g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
      6'd11: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      6'd12: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
      6'd13: g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
      6'd14: g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
      6'd15: g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
      6'd16: g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
      6'd17: g = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
      6'd18: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      6'd19: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      6'd20: g = {8'h01, 8'h3F, 8'h41, 8'h40, 8'h20};
      6'd21: g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
      6'd22: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
      6'd23: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      6'd24: g = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
      6'd25: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      6'd26: g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
      6'd27: g = {8'h5E, 8'h21, 8'h51, 8'h41, 8'h3E};
      6'd28: g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
      6'd29: g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
      6'd30: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      6'd31: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      6'd32: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      6'd33: g = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
      6'd34: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      6'd35: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      6'd36: g = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
      default: g = 40'd0;
    endcase
    return g;
  endfunction

endpackage

// ----- sv/gfr_if.sv -----
interface gfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_code;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [8:0] byte_address;

  modport source (
    output valid, opcode, char_code, pos_x, pos_y, byte_address,
    input  ready
  );
  modport sink (
    input  valid, opcode, char_code, pos_x, pos_y, byte_address,
    output ready
  );
endinterface

interface gfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// ----- sv/gfr_ctrl.sv -----
module gfr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  gfr_pkg::gfr_sts_t sts,
  output gfr_pkg::gfr_cmd_t cmd
);

  gfr_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == gfr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gfr_pkg::ST_INIT: begin
        if (sts.clr_last) state_nxt = gfr_pkg::ST_IDLE;
      end
      gfr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = gfr_pkg::ST_DECODE;
      end
      gfr_pkg::ST_DECODE: begin
        unique case (sts.op)
          gfr_pkg::OP_CLEAR: state_nxt = gfr_pkg::ST_CLEAR;
          gfr_pkg::OP_DRAW: begin
            state_nxt = sts.draw_ok ? gfr_pkg::ST_DRAW_RD : gfr_pkg::ST_DONE;
          end
          default: state_nxt = gfr_pkg::ST_DONE;
        endcase
      end
      gfr_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = gfr_pkg::ST_DONE;
      end
      gfr_pkg::ST_DRAW_RD: state_nxt = gfr_pkg::ST_DRAW_WR;
      gfr_pkg::ST_DRAW_WR: begin
        state_nxt = sts.col_done ? gfr_pkg::ST_DONE : gfr_pkg::ST_DRAW_RD;
      end
      gfr_pkg::ST_DONE: begin
        if (out_free) state_nxt = gfr_pkg::ST_IDLE;
      end
      default: state_nxt = gfr_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      gfr_pkg::ST_INIT:    cmd.clr_write = 1'b1;
      gfr_pkg::ST_IDLE:    cmd.latch = in_valid;
      gfr_pkg::ST_DECODE: begin
        cmd.col_start = (sts.op == gfr_pkg::OP_DRAW);
        cmd.byte_read = (sts.op == gfr_pkg::OP_READ);
      end
      gfr_pkg::ST_CLEAR:   cmd.clr_write = 1'b1;
      gfr_pkg::ST_DRAW_RD: cmd.col_read = 1'b1;
      gfr_pkg::ST_DRAW_WR: cmd.col_write = 1'b1;
      gfr_pkg::ST_DONE:    cmd.load_result = out_free;
      default:             cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gfr_pkg::ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/gfr_datapath.sv -----
module gfr_datapath #(
  parameter int COLUMNS = gfr_pkg::COLUMNS_DEF,
  parameter int PAGES   = gfr_pkg::PAGES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic [1:0]        in_opcode,
  input  logic [7:0]        in_char_code,
  input  logic [7:0]        in_pos_x,
  input  logic [7:0]        in_pos_y,
  input  logic [8:0]        in_byte_address,
  output logic [7:0]        out_read_data,
  input  gfr_pkg::gfr_cmd_t cmd,
  output gfr_pkg::gfr_sts_t sts
);

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q_r;

  logic             disp_en_r;
  gfr_pkg::opcode_t op_r;
  logic [7:0]       code_r, x_r, y_r;
  logic [8:0]       baddr_r;
  logic [2:0]       col_r;
  logic [AW-1:0]    clr_cnt_r;
  logic [7:0]       bits_r;
  logic [7:0]       out_data_r;

  gfr_pkg::glyph_sel_t glyph;
  logic [39:0]         glyph_cols;
  logic [7:0]          font_col;
  logic [14:0]         shifted;
  logic [9:0]          col_sum;
  logic [15:0]         draw_lin;
  logic [AW-1:0]       draw_addr;
  logic [AW-1:0]       mem_addr;
  logic                mem_we;
  logic [7:0]          mem_wdata;
  logic                addr_ok;

  assign glyph      = gfr_pkg::glyph_lookup(code_r);
  assign glyph_cols = gfr_pkg::font_glyph(glyph.idx);
  assign font_col   = glyph_cols[col_r*8 +: 8];
  // Drop rows shifted past the bottom of the page.
  assign shifted    = 15'(font_col & gfr_pkg::GLYPH_ROWS_MASK) << y_r[2:0];

  assign col_sum   = 10'(x_r) + 10'(col_r);
  assign draw_lin  = 16'(y_r[7:3]) * 16'(COLUMNS) + 16'(col_sum);
  assign draw_addr = draw_lin[AW-1:0];
  assign addr_ok   = 12'(baddr_r) < 12'(DEPTH);

  assign sts.op       = op_r;
  assign sts.draw_ok  = disp_en_r && glyph.ok && (9'(x_r) < 9'(COLUMNS))
                        && (9'(y_r) < 9'(PAGES * 8));
  assign sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));
  assign sts.col_done = (col_r == 3'(gfr_pkg::GLYPH_WIDTH - 1))
                        || ((col_sum + 10'd1) >= 10'(COLUMNS));

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 8'd0;
    mem_addr  = AW'(baddr_r);
    priority if (cmd.clr_write) begin
      mem_we   = 1'b1;
      mem_addr = clr_cnt_r;
    end else if (cmd.col_write) begin
      mem_we    = 1'b1;
      mem_wdata = mem_q_r | bits_r;
      mem_addr  = draw_addr;
    end else if (cmd.col_read) begin
      mem_addr = draw_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (cmd.col_read || cmd.byte_read) mem_q_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_en_r <= 1'b0;
      col_r     <= 3'd0;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_wr_en) disp_en_r <= cfg_wr_data;
      if (cmd.col_start) begin
        col_r <= 3'd0;
      end else if (cmd.col_write) begin
        col_r <= col_r + 3'd1;
      end
      if (cmd.clr_write) begin
        clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= gfr_pkg::opcode_t'(in_opcode);
      code_r  <= in_char_code;
      x_r     <= in_pos_x;
      y_r     <= in_pos_y;
      baddr_r <= in_byte_address;
    end
    if (cmd.col_read) bits_r <= shifted[7:0];
    if (cmd.load_result) begin
      out_data_r <= (op_r == gfr_pkg::OP_READ && addr_ok) ? mem_q_r : 8'd0;
    end
  end

  assign out_read_data = out_data_r;

endmodule

// ----- sv/glyph_framebuffer_renderer.sv -----
// Accept to result valid: a read passes DECODE and DONE, a draw adds a read
// and a write per glyph column through the single-port store, and a clear
// writes all COLUMNS*PAGES bytes in CLEAR. One operation at a time: a new
// beat is taken only after the last result is loaded into the output
// register, where it may wait. Reset (rst_n low, synchronous) starts a
// clearing pass with in_ch.ready low; configuration writes are taken meanwhile.
module glyph_framebuffer_renderer #(
  parameter int COLUMNS = gfr_pkg::COLUMNS_DEF,
  parameter int PAGES   = gfr_pkg::PAGES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  gfr_in_if.sink           in_ch,
  gfr_out_if.source        out_ch
);

  // Command and status between sequencer and datapath.
  gfr_pkg::gfr_cmd_t cmd;
  gfr_pkg::gfr_sts_t sts;

  // Sequencer: owns the handshake and walks each operation through the
  // store one access per cycle.
  gfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: frame store, font lookup, clear counter, column counter
  // and the result register.
  gfr_datapath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_opcode       (in_ch.opcode),
    .in_char_code    (in_ch.char_code),
    .in_pos_x        (in_ch.pos_x),
    .in_pos_y        (in_ch.pos_y),
    .in_byte_address (in_ch.byte_address),
    .out_read_data   (out_ch.read_data),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ----- sv/gfr_checker.sv -----
module gfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // Clearing pass follows reset: no beat is taken straight after it.
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready straight after reset");

  // After a beat is taken, ready stays low while the operation passes DECODE and DONE.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready ##1 !in_ready)
    else $error("input ready too soon after a beat");

  // No result appears in the cycle after a beat is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !$rose(out_valid))
    else $error("result raised too early");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(read_data))
    else $error("stalled result changed");

endmodule

bind glyph_framebuffer_renderer gfr_checker u_gfr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .read_data (out_ch.read_data)
);

// ----- sim/glyph_framebuffer_renderer_tb.sv -----
`timescale 1ns / 100ps

module glyph_framebuffer_renderer_tb;

  localparam int COLUMNS     = gfr_pkg::COLUMNS_DEF;
  localparam int PAGES       = gfr_pkg::PAGES_DEF;
  localparam int STORE_BYTES = COLUMNS * PAGES;
  localparam int PHASES      = 6;
  localparam int PHASE_OPS   = 190;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 16;
  localparam int MAX_SHOWN   = 10;

  // The one code the opcode field can carry that the block does not define.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [8:0] byte_address;
  } gfr_op_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] read_data;
  } read_back_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  gfr_in_if  in_ch ();
  gfr_out_if out_ch ();

  glyph_framebuffer_renderer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Shadow of the block: the page-organised store and the enable bit.
  logic [7:0] frame_shadow [0:STORE_BYTES-1] = '{default: 8'h00};
  logic       disp_on;

  gfr_op_t    pending_ops [$];
  read_back_t expected_bytes [$];

  // ops_pushed is written by the stimulus only and results_checked by the
  // monitor only, so draining needs no shared counter.
  int ops_pushed;
  int results_checked = 0;
  int beats_taken = 0;
  int phase_ops;
  int fail_count = 0;
  int shown = 0;
  bit gaps_on;

  int         send_idle;
  int         recv_idle;
  int         hold_left;
  gfr_op_t    accepted_op;
  gfr_op_t    next_op;
  read_back_t got_exp;
  read_back_t new_exp;

  initial begin
    forever #5 clk = ~clk;
  end

  // Five glyph columns, leftmost first in the top byte; bit j is glyph row j.
  function automatic logic [39:0] glyph_bits(input int slot);
    logic [39:0] g;
    case (slot)
      0:  g = 40'h0000000000;
      1:  g = 40'h3E5149453E;
      2:  g = 40'h00427F4000;
      3:  g = 40'h4261514946;
      4:  g = 40'h2141454B31;
      5:  g = 40'h1814127F10;
      6:  g = 40'h2745454539;
      7:  g = 40'h3C4A494930;
      8:  g = 40'h0171090503;
      9:  g = 40'h3649494936;
      10: g = 40'h064949291E;
      11: g = 40'h7E1111117E;
      12: g = 40'h7F49494936;
      13: g = 40'h3E41414122;
      14: g = 40'h7F4141221C;
      15: g = 40'h7F49494941;
      16: g = 40'h7F09090901;
      17: g = 40'h3E4149497A;
      18: g = 40'h7F0808087F;
      19: g = 40'h00417F4100;
      20: g = 40'h2040413F01;
      21: g = 40'h7F08142241;
      22: g = 40'h7F40404040;
      23: g = 40'h7F020C027F;
      24: g = 40'h7F0408107F;
      25: g = 40'h3E4141413E;
      26: g = 40'h7F09090906;
      27: g = 40'h3E4151215E;
      28: g = 40'h7F09192946;
      29: g = 40'h4649494931;
      30: g = 40'h01017F0101;
      31: g = 40'h3F4040403F;
      32: g = 40'h1F2040201F;
      33: g = 40'h7F2018207F;
      34: g = 40'h6314081463;
      35: g = 40'h0708700807;
      36: g = 40'h6151494543;
      default: g = 40'h0;
    endcase
    return g;
  endfunction

  // Font slot for a character: space, digits, then letters; -1 if not in the font.
  function automatic int font_slot(input logic [7:0] code);
    if (code >= CH_ZERO && code <= CH_ZERO + 8'd9)
      return int'(code - CH_ZERO) + 1;
    if (code >= CH_A && code <= CH_A + 8'd25)
      return int'(code - CH_A) + 11;
    if (code == CH_SPACE)
      return 0;
    return -1;
  endfunction

  // Apply one operation to the shadow store and return the byte the block must send back.
  function automatic logic [7:0] render_step(input gfr_op_t op);
    logic [7:0]  result;
    logic [7:0]  bits;
    logic [39:0] g;
    int          slot;
    int          page;
    int          col;
    int          c;
    result = 8'h00;
    case (op.opcode)
      gfr_pkg::OP_CLEAR: begin
        for (int i = 0; i < STORE_BYTES; i++)
          frame_shadow[i] = 8'h00;
      end
      gfr_pkg::OP_DRAW: begin
        slot = font_slot(op.char_code);
        if (disp_on && op.pos_x < COLUMNS && op.pos_y < PAGES * 8 && slot >= 0) begin
          g    = glyph_bits(slot);
          page = int'(op.pos_y >> 3);
          for (c = 0; c < gfr_pkg::GLYPH_WIDTH; c++) begin
            col = int'(op.pos_x) + c;
            if (col < COLUMNS) begin
              // rows pushed past bit 7 fall off; they never reach the next page
              bits = (g[39 - 8 * c -: 8] & 8'h7F) << op.pos_y[2:0];
              frame_shadow[page * COLUMNS + col] = frame_shadow[page * COLUMNS + col] | bits;
            end
          end
        end
      end
      gfr_pkg::OP_READ: begin
        if (op.byte_address < STORE_BYTES)
          result = frame_shadow[op.byte_address];
      end
      default: ;
    endcase
    return result;
  endfunction

  // Mostly back-to-back, now and then a short gap, rarely a long pause; none while gaps are off.
  function automatic int pick_gap();
    int r;
    if (!gaps_on)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [8:0] store_addr(input int page, input int col);
    return 9'(page * COLUMNS + col);
  endfunction

  task automatic push_op(input logic [1:0] opc, input logic [7:0] code,
                         input logic [7:0] x, input logic [7:0] y, input logic [8:0] addr);
    gfr_op_t op;
    op.opcode       = opc;
    op.char_code    = code;
    op.pos_x        = x;
    op.pos_y        = y;
    op.byte_address = addr;
    pending_ops.push_back(op);
    ops_pushed++;
    phase_ops++;
  endtask

  // Reads carry random junk in the unused fields.
  task automatic push_read(input logic [8:0] addr);
    push_op(gfr_pkg::OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), addr);
  endtask

  // Draw, then read back every column it may touch, and the page below if asked.
  task automatic push_draw_check(input logic [7:0] code, input int x, input int y,
                                 input bit next_page);
    int c;
    push_op(gfr_pkg::OP_DRAW, code, 8'(x), 8'(y), 9'($urandom));
    for (c = 0; c < gfr_pkg::GLYPH_WIDTH; c++) begin
      if (x + c < COLUMNS) begin
        push_read(store_addr(y >> 3, x + c));
        if (next_page && (y >> 3) + 1 < PAGES)
          push_read(store_addr((y >> 3) + 1, x + c));
      end
    end
  endtask

  function automatic logic [7:0] pick_font_char();
    int r;
    r = $urandom_range(0, 36);
    if (r == 0)
      return CH_SPACE;
    if (r <= 10)
      return CH_ZERO + 8'(r - 1);
    return CH_A + 8'(r - 11);
  endfunction

  // Mostly well-formed text with read-back, plus clears, noise, stray reads and the spare opcode.
  task automatic queue_random_ops(input int count);
    int r;
    int x;
    phase_ops = 0;
    while (phase_ops < count) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        push_op(gfr_pkg::OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 9'($urandom));
        push_read(9'($urandom));
      end else if (r < 70) begin
        x = ($urandom_range(0, 9) < 3) ? $urandom_range(COLUMNS - 10, COLUMNS - 1)
                                         : $urandom_range(0, COLUMNS - 1);
        push_draw_check(pick_font_char(), x, $urandom_range(0, PAGES * 8 - 1),
                        1'($urandom_range(0, 1)));
      end else if (r < 80) begin
        push_op(gfr_pkg::OP_DRAW, 8'($urandom), 8'($urandom), 8'($urandom), 9'($urandom));
        push_read(9'($urandom));
      end else if (r < 99) begin
        push_read(9'($urandom));
      end else begin
        push_op(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 9'($urandom));
      end
    end
  endtask

  // Hold until every beat handed over has come back, then let the block settle.
  task automatic wait_drained();
    while (results_checked < ops_pushed)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The block is idle here, so the shadow bit can follow at once.
  task automatic write_display_enable(input logic value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    disp_on = value;
  endtask

  // Sender: predict on every accepted beat, then offer the next one after its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.opcode       <= gfr_pkg::OP_CLEAR;
      in_ch.char_code    <= 8'h00;
      in_ch.pos_x        <= 8'h00;
      in_ch.pos_y        <= 8'h00;
      in_ch.byte_address <= 9'h000;
      send_idle = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accepted_op.opcode       = in_ch.opcode;
        accepted_op.char_code    = in_ch.char_code;
        accepted_op.pos_x        = in_ch.pos_x;
        accepted_op.pos_y        = in_ch.pos_y;
        accepted_op.byte_address = in_ch.byte_address;
        new_exp.opcode    = accepted_op.opcode;
        new_exp.read_data = render_step(accepted_op);
        expected_bytes.push_back(new_exp);
        send_idle = pick_gap();
      end
      // only move on once the current beat is gone; a held beat stays untouched
      if (!in_ch.valid || in_ch.ready) begin
        if (send_idle > 0) begin
          send_idle--;
          in_ch.valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          next_op = pending_ops.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.opcode       <= next_op.opcode;
          in_ch.char_code    <= next_op.char_code;
          in_ch.pos_x        <= next_op.pos_x;
          in_ch.pos_y        <= next_op.pos_y;
          in_ch.byte_address <= next_op.byte_address;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result beat against the oldest expectation, and
  // throttle ready. Twice in the run it holds off for a long stretch so that
  // the output register fills and the block stops taking input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_idle = 0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        beats_taken++;
        if (expected_bytes.size() == 0) begin
          fail_count++;
          if (shown < MAX_SHOWN)
            $display("unexpected result beat: read_data 0x%02h", out_ch.read_data);
          shown++;
        end else begin
          got_exp = expected_bytes.pop_front();
          results_checked++;
          if (out_ch.read_data !== got_exp.read_data) begin
            fail_count++;
            if (shown < MAX_SHOWN)
              $display("read_data mismatch, opcode %0d: expected 0x%02h, got 0x%02h",
                       got_exp.opcode, got_exp.read_data, out_ch.read_data);
            shown++;
          end
        end
        if (beats_taken == 300 || beats_taken == 800)
          hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_idle > 0) begin
        recv_idle--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_idle = pick_gap();
      end
    end
  end

  initial begin
    // Hold reset and keep the configuration port quiet before the first edge.
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = 1'b0;
    gaps_on            = 1'b0;
    disp_on            = 1'b0;
    ops_pushed         = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Display still off from reset: the store is blank and draws leave it so.
    push_read(9'd0);
    push_read(9'(STORE_BYTES - 1));
    push_op(gfr_pkg::OP_DRAW, CH_A, 8'd0, 8'd0, 9'd0);
    push_read(9'd0);
    wait_drained();
    write_display_enable(1'b1);

    // Plain draw at the origin.
    push_op(gfr_pkg::OP_DRAW, CH_ZERO + 8'd8, 8'd0, 8'd0, 9'd0);
    push_read(store_addr(0, 0));
    push_read(store_addr(0, 4));
    // Right edge: only the first three columns land.
    push_op(gfr_pkg::OP_DRAW, CH_A + 8'd25, 8'(COLUMNS - 3), 8'd0, 9'd0);
    push_read(store_addr(0, COLUMNS - 1));
    // Page boundary: lower rows are cut, not carried into page 1.
    push_op(gfr_pkg::OP_DRAW, CH_A + 8'd22, 8'd10, 8'd5, 9'd0);
    push_read(store_addr(0, 10));
    push_read(store_addr(1, 10));
    // Off-screen origins in x and in y, at the threshold and at the top.
    push_op(gfr_pkg::OP_DRAW, CH_A + 8'd12, 8'(COLUMNS), 8'd8, 9'd0);
    push_op(gfr_pkg::OP_DRAW, CH_A + 8'd12, 8'hFF, 8'd8, 9'd0);
    push_op(gfr_pkg::OP_DRAW, CH_A + 8'd12, 8'd20, 8'(PAGES * 8), 9'd0);
    push_op(gfr_pkg::OP_DRAW, CH_A + 8'd12, 8'd20, 8'hFF, 9'd0);
    push_read(store_addr(1, 0));
    push_read(store_addr(0, 20));
    // Characters outside the font.
    push_op(gfr_pkg::OP_DRAW, 8'hFF, 8'd50, 8'd8, 9'd0);
    push_op(gfr_pkg::OP_DRAW, 8'h00, 8'd51, 8'd8, 9'd0);
    push_op(gfr_pkg::OP_DRAW, 8'h61, 8'd52, 8'd8, 9'd0);
    push_read(store_addr(1, 52));
    // Space is blank, the spare opcode does nothing.
    push_op(gfr_pkg::OP_DRAW, CH_SPACE, 8'd0, 8'd0, 9'd0);
    push_op(OP_UNUSED, CH_A, 8'd0, 8'd0, 9'd0);
    push_read(9'd0);
    // Bottom-right corner, then clear.
    push_op(gfr_pkg::OP_DRAW, CH_ZERO, 8'(COLUMNS - 1), 8'(PAGES * 8 - 1), 9'h1FF);
    push_read(9'(STORE_BYTES - 1));
    push_op(gfr_pkg::OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 9'h1FF);
    push_read(9'(STORE_BYTES - 1));
    wait_drained();

    // Random phases: the first runs without idling, the enable bit is cleared
    // for the second and fifth phases, and each phase boundary pauses the sender until the
    // block has returned everything.
    for (int p = 0; p < PHASES; p++) begin
      write_display_enable((p % 3) != 1);
      gaps_on = (p != 0);
      queue_random_ops(PHASE_OPS);
      wait_drained();
    end

    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
